[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the run list lookup checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is active
`define RLVL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define RLVL_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rlvl_pkg.sv]
// ----------------------------------------------------------------------------
// rlvl_pkg
// types and constants for the run list vcn to lcn lookup
// ----------------------------------------------------------------------------
`default_nettype none

package rlvl_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int VCN_W      = 48;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // staging width for placing one byte at any of the sixteen byte slots
  localparam int PLACE_W    = 128;

  // decoder phase within one run
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED       = 2'd0,
    ST_SPARSE       = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_VCN  = 1'b0,
    CFG_HIGH_VCN = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/rlvl_in_if.sv]
// ----------------------------------------------------------------------------
// rlvl_in_if
// run list byte stream channel: one list byte plus the query per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface rlvl_in_if import rlvl_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] run_byte;
  logic              first_byte;
  logic [VCN_W-1:0]  query_vcn;

  modport source (output valid, run_byte, first_byte, query_vcn, input ready);
  modport sink   (input valid, run_byte, first_byte, query_vcn, output ready);

endinterface

`default_nettype wire

[rtl/rlvl_out_if.sv]
// ----------------------------------------------------------------------------
// rlvl_out_if
// lookup result channel: status, mapped lcn and clusters left in the run
// ----------------------------------------------------------------------------
`default_nettype none

interface rlvl_out_if import rlvl_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VCN_W-1:0]    lcn;
  logic [VCN_W-1:0]    run_count;

  modport source (output valid, status, lcn, run_count, input ready);
  modport sink   (input valid, status, lcn, run_count, output ready);

endinterface

`default_nettype wire

[rtl/runlist_vcn_to_lcn_lookup_unit.sv]
// ----------------------------------------------------------------------------
// runlist_vcn_to_lcn_lookup_unit
// streams an extent run list byte by byte and maps a query vcn to its lcn
// ----------------------------------------------------------------------------
// The block takes one run list byte per clock cycle, every cycle, for as long
// as the result side keeps up: each byte updates the decoder state in the
// cycle it is transferred, and any result is registered for the next cycle.
// The single output register with ready feed-through sets the rate: a new byte
// is taken whenever that register is empty or is being drained in the same
// cycle. The longest path is the end-of-run step: the last byte is merged, the
// offset is added to the running lcn and the query is tested against the run
// bounds. Bytes after a result are dropped until the next first byte;
// the user must write configuration only while idle, which is not enforced.
`default_nettype none

module runlist_vcn_to_lcn_lookup_unit import rlvl_pkg::*; #(
  parameter int CLUSTER_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rlvl_in_if.sink               in_chan,
  rlvl_out_if.source            out_chan
);

  localparam int CB = CLUSTER_BITS;
  localparam int WW = (CB > VCN_W) ? CB : VCN_W;
  localparam int OW = (CB < VCN_W) ? CB : VCN_W;

  // configuration
  logic [VCN_W-1:0] low_vcn_r, high_vcn_r;

  // decoder state
  phase_t           phase_r, phase_nxt;
  logic [NIB_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [NIB_W-1:0] length_bytes_r, length_bytes_nxt;
  logic [NIB_W-1:0] offset_bytes_r, offset_bytes_nxt;
  logic [CB-1:0]    length_acc_r, length_acc_nxt;
  logic [CB-1:0]    delta_acc_r, delta_acc_nxt;
  logic [CB-1:0]    running_lcn_r, running_lcn_nxt;
  logic [CB-1:0]    base_vcn_r, base_vcn_nxt;
  logic             done_r, done_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r;
  logic [VCN_W-1:0] out_lcn_r, out_count_r;

  // decode signals
  logic              in_ready, in_fire;
  logic [BYTE_W-1:0] b;
  logic              first;
  logic [VCN_W-1:0]  q;
  logic              out_of_range, eff_done, act;
  phase_t            eff_phase;
  logic [NIB_W-1:0]  byte_idx, bl_dec;
  logic [CB-1:0]     placed, ext, count_fin, delta_fin, run_new;
  logic              finish, sparse, hit;
  logic [WW-1:0]     qw, bw, cw, dw, lcn_w, rem_w;

  // result of this transfer
  logic              res_valid;
  status_t           res_status;
  logic [VCN_W-1:0]  res_lcn, res_count;

  // handshake
  assign in_ready       = !out_valid_r || out_chan.ready;
  assign in_fire        = in_chan.valid && in_ready;
  assign in_chan.ready  = in_ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.lcn       = out_lcn_r;
  assign out_chan.run_count = out_count_r;

  assign b     = in_chan.run_byte;
  assign first = in_chan.first_byte;
  assign q     = in_chan.query_vcn;

  // a first byte restarts the lookup and is decoded as a header
  assign out_of_range = (q < low_vcn_r) || (q > high_vcn_r);
  assign eff_done     = first ? 1'b0 : done_r;
  assign eff_phase    = first ? PH_HEADER : phase_r;
  assign act          = in_fire && !(first && out_of_range) && !eff_done;

  // byte slot within the current field, and byte placed into it
  assign byte_idx = (phase_r == PH_LENGTH) ? (length_bytes_r - bytes_left_r)
                                           : (offset_bytes_r - bytes_left_r);
  assign bl_dec   = bytes_left_r - 4'd1;
  assign placed   = CB'(PLACE_W'(b) << {byte_idx, 3'b000});

  // sign fill above the offset field; a field covering all CLUSTER_BITS fills nothing
  assign ext = CB'({PLACE_W{1'b1}} << {offset_bytes_r, 3'b000});

  // end of run: last length byte of a sparse run, or last offset byte
  assign finish = act && (bl_dec == '0) &&
                  (((eff_phase == PH_LENGTH) && (offset_bytes_r == '0)) ||
                   (eff_phase == PH_OFFSET));

  assign count_fin = (eff_phase == PH_LENGTH) ? (length_acc_r | placed) : length_acc_r;
  assign delta_fin = delta_acc_r | placed | (b[BYTE_W-1] ? ext : '0);
  assign sparse    = (offset_bytes_r == '0);
  assign run_new   = running_lcn_r + (sparse ? '0 : delta_fin);

  // match test without wrap
  assign qw    = WW'(q);
  assign bw    = WW'(base_vcn_r);
  assign cw    = WW'(count_fin);
  assign dw    = qw - bw;
  assign hit   = (bw <= qw) && (dw < cw);
  assign lcn_w = WW'(run_new) + dw;
  assign rem_w = cw - dw;

  // phase sequencing
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    if (in_fire && first) begin
      phase_nxt      = PH_HEADER;
      bytes_left_nxt = '0;
    end
    if (act) begin
      case (eff_phase)
        PH_HEADER: begin
          if (b != '0) begin
            if (b[NIB_W-1:0] != '0) begin
              phase_nxt      = PH_LENGTH;
              bytes_left_nxt = b[NIB_W-1:0];
            end else begin
              phase_nxt      = PH_OFFSET;
              bytes_left_nxt = b[BYTE_W-1:NIB_W];
            end
          end
        end
        PH_LENGTH: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == '0) begin
            if (offset_bytes_r != '0) begin
              phase_nxt      = PH_OFFSET;
              bytes_left_nxt = offset_bytes_r;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_OFFSET: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: ;
      endcase
    end
  end

  // accumulators, running cluster numbers and result
  always_comb begin
    length_bytes_nxt = length_bytes_r;
    offset_bytes_nxt = offset_bytes_r;
    length_acc_nxt   = length_acc_r;
    delta_acc_nxt    = delta_acc_r;
    running_lcn_nxt  = running_lcn_r;
    base_vcn_nxt     = base_vcn_r;
    done_nxt         = done_r;
    res_valid        = 1'b0;
    res_status       = ST_MAPPED;
    res_lcn          = '0;
    res_count        = '0;

    // restart, or report out of range at once
    if (in_fire && first) begin
      length_bytes_nxt = '0;
      offset_bytes_nxt = '0;
      length_acc_nxt   = '0;
      delta_acc_nxt    = '0;
      running_lcn_nxt  = '0;
      base_vcn_nxt     = CB'(low_vcn_r);
      done_nxt         = out_of_range;
      if (out_of_range) begin
        res_valid  = 1'b1;
        res_status = ST_OUT_OF_RANGE;
      end
    end

    if (act) begin
      case (eff_phase)
        PH_HEADER: begin
          if (b == '0) begin
            done_nxt   = 1'b1;
            res_valid  = 1'b1;
            res_status = ST_NOT_FOUND;
          end else begin
            length_bytes_nxt = b[NIB_W-1:0];
            offset_bytes_nxt = b[BYTE_W-1:NIB_W];
            length_acc_nxt   = '0;
            delta_acc_nxt    = '0;
          end
        end
        PH_LENGTH: length_acc_nxt = length_acc_r | placed;
        PH_OFFSET: delta_acc_nxt  = finish ? delta_fin : (delta_acc_r | placed);
        default: ;
      endcase
    end

    // run complete: apply offset, test for a match, else advance the base
    if (finish) begin
      running_lcn_nxt = run_new;
      if (hit) begin
        done_nxt   = 1'b1;
        res_valid  = 1'b1;
        res_status = sparse ? ST_SPARSE : ST_MAPPED;
        res_lcn    = sparse ? '0 : VCN_W'(lcn_w[OW-1:0]);
        res_count  = VCN_W'(rem_w[OW-1:0]);
      end else begin
        base_vcn_nxt = base_vcn_r + count_fin;
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_vcn_r    <= '0;
      high_vcn_r   <= '0;
      phase_r      <= PH_HEADER;
      bytes_left_r <= '0;
      done_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LOW_VCN:  low_vcn_r  <= cfg_wdata;
          CFG_HIGH_VCN: high_vcn_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    length_bytes_r <= length_bytes_nxt;
    offset_bytes_r <= offset_bytes_nxt;
    length_acc_r   <= length_acc_nxt;
    delta_acc_r    <= delta_acc_nxt;
    running_lcn_r  <= running_lcn_nxt;
    base_vcn_r     <= base_vcn_nxt;
    if (in_fire && res_valid) begin
      out_status_r <= res_status;
      out_lcn_r    <= res_lcn;
      out_count_r  <= res_count;
    end
  end

endmodule

`default_nettype wire

[rtl/rlvl_checker.sv]
// ----------------------------------------------------------------------------
// rlvl_checker
// port level checks on the run list lookup, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlvl_checker import rlvl_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [VCN_W-1:0]    out_lcn,
  input wire logic [VCN_W-1:0]    out_run_count
);

  // a stalled result stays offered
  `RLVL_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // an empty output register never blocks the byte stream
  `RLVL_ASSERT(a_in_ready, clk, rst_n, !out_valid |-> in_ready, "input stalled with no result pending")

  // only a mapped run carries an lcn
  `RLVL_ASSERT(a_lcn_zero, clk, rst_n, out_valid && (out_status != ST_MAPPED) |-> out_lcn == '0, "lcn set on an unmapped result")

  // not found and out of range carry no cluster count
  `RLVL_ASSERT(a_count_zero, clk, rst_n, out_valid && ((out_status == ST_NOT_FOUND) || (out_status == ST_OUT_OF_RANGE)) |-> out_run_count == '0, "run count set without a matching run")

  // reset empties the output register
  `RLVL_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind runlist_vcn_to_lcn_lookup_unit rlvl_checker u_rlvl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_status    (out_chan.status),
  .out_lcn       (out_chan.lcn),
  .out_run_count (out_chan.run_count)
);

`default_nettype wire
